// ===== sv/tetra_barycentric_weights_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TETRA_BARYCENTRIC_WEIGHTS_CORE_DEFINES_SVH
`define TETRA_BARYCENTRIC_WEIGHTS_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define TBW_ASSERT_IMP(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("tbw check failed");

// next-cycle implication, off during reset
`define TBW_ASSERT_NXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("tbw check failed");

// next-cycle implication, also checked across reset
`define TBW_ASSERT_RST(lbl, ck, pre, post) \
  lbl: assert property (@(posedge ck) (pre) |=> (post)) \
    else $error("tbw check failed");

`endif

// ===== sv/tbw_pkg.sv =====
package tbw_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int WEIGHT_FRAC_DEF = 30;
  localparam int IN_COORD_W      = 32;
  localparam int OUT_W           = 48;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic [1:0]                   vertex_index;
    logic signed [IN_COORD_W-1:0] x;
    logic signed [IN_COORD_W-1:0] y;
    logic signed [IN_COORD_W-1:0] z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] w0;
    logic signed [OUT_W-1:0] w1;
    logic signed [OUT_W-1:0] w2;
    logic signed [OUT_W-1:0] w3;
    logic                    singular;
    logic                    saturated;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MSET,
    ST_MRUN,
    ST_NEGD,
    ST_NSET,
    ST_DRUN,
    ST_WOUT,
    ST_FIN,
    ST_DONE
  } state_t;

  // the two rows (or columns) of a 3x3 matrix left when one is struck out
  function automatic logic [1:0] other_lo(input logic [1:0] k);
    return (k == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] other_hi(input logic [1:0] k);
    return (k == 2'd2) ? 2'd1 : 2'd2;
  endfunction

endpackage

// ===== sv/tbw_alu.sv =====
module tbw_alu #(
  parameter int W = 104
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum
);

  assign sum = a + (sub ? ~b : b) + W'(sub);

endmodule

// ===== sv/tetra_barycentric_weights_core.sv =====
// channel | signals                        | payload
// in      | in_valid, in_stall, in_data    | tbw_pkg::in_t  (load vertex / query point)
// out     | out_valid, out_stall, out_data | tbw_pkg::out_t (weights, flags)
//
// A load writes one vertex of the store. A query runs on one shared add/sub unit:
// 30 bit-serial multiply terms, then three restoring divisions, with control states
// between them; when the matrix is singular the divisions are skipped.
// Synchronous active-high reset clears the control state and the vertex store.
// in_stall is high from a query request until its result is in the output register;
// a stalled output holds the block in its final state only until the register frees.
module tetra_barycentric_weights_core #(
  parameter int COORD_WIDTH      = tbw_pkg::COORD_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tbw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tbw_pkg::out_t out_data
);
  import tbw_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int CWI = (CW < IN_COORD_W) ? CW : IN_COORD_W;
  localparam int EW  = CW + 1;
  localparam int CFW = 2 * EW + 1;
  localparam int TW  = 3 * EW + 3;
  localparam int AW  = TW + 1;
  localparam int NW  = TW + F;
  localparam int BCW = $clog2(NW + 1);

  localparam logic signed [TW-1:0] OUT_HI = {{(TW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [TW-1:0] OUT_LO = ~OUT_HI;

  function automatic logic signed [CW-1:0] to_coord(input logic [IN_COORD_W-1:0] v);
    return CW'(signed'(v[CWI-1:0]));
  endfunction

  state_t state, state_next;

  logic signed [CW-1:0]  vstore [4][3];
  logic signed [EW-1:0]  e [3][3];
  logic signed [EW-1:0]  q [3];
  logic signed [CFW-1:0] cof [3][3];
  logic signed [TW-1:0]  det;
  logic signed [TW-1:0]  num [3];
  logic signed [TW-1:0]  acc;
  logic [EW-1:0]         a_sh;
  logic signed [TW-1:0]  b_sh;
  logic [TW-1:0]         dmag;
  logic [TW-1:0]         rem;
  logic [NW-1:0]         div_sh;
  logic [NW-1:0]         quo;
  logic                  neg;
  logic signed [OUT_W-1:0] wt [3];
  logic signed [OUT_W-1:0] w0r;
  logic                  sat;
  logic                  sing;
  logic                  phase;
  logic [1:0]            kr, ki, tc;
  logic [BCW-1:0]        bitc;

  logic signed [CW-1:0]  pin [3];
  logic                  in_acc;
  logic [AW-1:0]         alu_a, alu_b, alu_sum;
  logic                  alu_sub;

  logic [1:0]            lo_r, hi_r, lo_i, hi_i, dcol;
  logic signed [EW-1:0]  op_a;
  logic signed [CFW-1:0] op_b;
  logic                  term_neg, last_bit, last_term, prod_last;
  logic signed [TW-1:0]  acc_new;
  logic [TW-1:0]         nmag;
  logic                  qbit;
  logic                  w_over;
  logic [OUT_W-1:0]      lim, lowv, magc;
  logic signed [OUT_W-1:0] wv;
  logic signed [TW-1:0]  fin_s;

  tbw_alu #(.W(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign pin[0] = to_coord(in_data.x);
  assign pin[1] = to_coord(in_data.y);
  assign pin[2] = to_coord(in_data.z);

  // operand selection for the multiply terms
  always_comb begin
    lo_r = other_lo(kr);
    hi_r = other_hi(kr);
    lo_i = other_lo(ki);
    hi_i = other_hi(ki);
    dcol = (ki == 2'd0) ? 2'd0 : ki - 2'd1;
    if (!phase) begin
      op_a     = (tc == 2'd0) ? e[lo_r][lo_i] : e[lo_r][hi_i];
      op_b     = CFW'((tc == 2'd0) ? e[hi_r][hi_i] : e[hi_r][lo_i]);
      term_neg = kr[0] ^ ki[0] ^ tc[0];
    end else begin
      op_a     = (ki == 2'd0) ? e[tc][0] : q[tc];
      op_b     = cof[tc][dcol];
      term_neg = 1'b0;
    end
    last_bit  = (bitc == BCW'(EW - 1));
    last_term = phase ? (tc == 2'd2) : (tc == 2'd1);
    prod_last = phase ? (ki == 2'd3) : (kr == 2'd2 && ki == 2'd2);
  end

  // shared unit input selection
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state)
      ST_MRUN: begin
        alu_a   = AW'(acc);
        alu_b   = AW'(b_sh);
        alu_sub = term_neg ^ last_bit;
      end
      ST_NEGD: alu_b = AW'(det);
      ST_NSET: alu_b = AW'(num[ki]);
      ST_DRUN: begin
        alu_a = {rem, div_sh[NW-1]};
        alu_b = AW'(dmag);
      end
      ST_FIN: begin
        alu_a = (tc == 2'd0) ? (AW'(1) << F) : AW'(acc);
        alu_b = AW'(wt[tc]);
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    acc_new = a_sh[0] ? signed'(alu_sum[TW-1:0]) : acc;
    nmag    = num[ki][TW-1] ? alu_sum[TW-1:0] : num[ki];
    qbit    = !alu_sum[AW-1];
    lim     = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    lowv    = quo[OUT_W-1:0];
    w_over  = (|quo[NW-1:OUT_W]) || (lowv > lim);
    magc    = w_over ? lim : lowv;
    wv      = neg ? -signed'(magc) : signed'(magc);
    fin_s   = signed'(alu_sum[TW-1:0]);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && in_data.cmd == CMD_QUERY) state_next = ST_MSET;
      ST_MSET: state_next = ST_MRUN;
      ST_MRUN: begin
        if (last_bit) begin
          if (phase && last_term && prod_last) begin
            state_next = (det == '0) ? ST_DONE : ST_NEGD;
          end else begin
            state_next = ST_MSET;
          end
        end
      end
      ST_NEGD: state_next = ST_NSET;
      ST_NSET: state_next = ST_DRUN;
      ST_DRUN: if (bitc == BCW'(NW - 1)) state_next = ST_WOUT;
      ST_WOUT: state_next = (ki == 2'd2) ? ST_FIN : ST_NSET;
      ST_FIN:  if (tc == 2'd2) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < 4; v++) begin
        for (int c = 0; c < 3; c++) vstore[v][c] <= '0;
      end
    end else if (in_acc && in_data.cmd == CMD_LOAD) begin
      for (int c = 0; c < 3; c++) vstore[in_data.vertex_index][c] <= pin[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      kr    <= '0;
      ki    <= '0;
      tc    <= '0;
      bitc  <= '0;
      sat   <= 1'b0;
      sing  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && in_data.cmd == CMD_QUERY) begin
            phase <= 1'b0;
            kr    <= '0;
            ki    <= '0;
            tc    <= '0;
            sat   <= 1'b0;
            sing  <= 1'b0;
            for (int r = 0; r < 3; r++) begin
              q[r] <= EW'(pin[r]) - EW'(vstore[0][r]);
              for (int c = 0; c < 3; c++) begin
                e[r][c] <= EW'(vstore[c+1][r]) - EW'(vstore[0][r]);
              end
            end
          end
        end
        ST_MSET: begin
          a_sh <= op_a;
          b_sh <= TW'(op_b);
          bitc <= '0;
          if (tc == 2'd0) acc <= '0;
        end
        ST_MRUN: begin
          acc  <= acc_new;
          a_sh <= a_sh >> 1;
          b_sh <= b_sh <<< 1;
          bitc <= bitc + BCW'(1);
          if (last_bit) begin
            if (last_term) begin
              tc <= '0;
              if (!phase) begin
                cof[kr][ki] <= CFW'(acc_new);
              end else if (ki == 2'd0) begin
                det <= acc_new;
              end else begin
                num[dcol] <= acc_new;
              end
              if (prod_last) begin
                if (!phase) begin
                  phase <= 1'b1;
                  kr    <= '0;
                  ki    <= '0;
                end else if (det == '0) begin
                  sing <= 1'b1;
                  w0r  <= '0;
                  for (int i = 0; i < 3; i++) wt[i] <= '0;
                end
              end else if (!phase && ki == 2'd2) begin
                ki <= '0;
                kr <= kr + 2'd1;
              end else begin
                ki <= ki + 2'd1;
              end
            end else begin
              tc <= tc + 2'd1;
            end
          end
        end
        ST_NEGD: begin
          dmag <= det[TW-1] ? alu_sum[TW-1:0] : det;
          ki   <= '0;
        end
        ST_NSET: begin
          div_sh <= {nmag, {F{1'b0}}};
          neg    <= num[ki][TW-1] ^ det[TW-1];
          rem    <= '0;
          quo    <= '0;
          bitc   <= '0;
        end
        ST_DRUN: begin
          rem    <= qbit ? alu_sum[TW-1:0] : {rem[TW-2:0], div_sh[NW-1]};
          div_sh <= div_sh << 1;
          quo    <= {quo[NW-2:0], qbit};
          bitc   <= bitc + BCW'(1);
        end
        ST_WOUT: begin
          wt[ki] <= wv;
          sat    <= sat | w_over;
          ki     <= ki + 2'd1;
          tc     <= '0;
        end
        ST_FIN: begin
          acc <= fin_s;
          tc  <= tc + 2'd1;
          if (tc == 2'd2) begin
            // w0 = 1 - w1 - w2 - w3, clipped to the output range
            if (fin_s > OUT_HI) begin
              w0r <= OUT_HI[OUT_W-1:0];
              sat <= 1'b1;
            end else if (fin_s < OUT_LO) begin
              w0r <= OUT_LO[OUT_W-1:0];
              sat <= 1'b1;
            end else begin
              w0r <= fin_s[OUT_W-1:0];
            end
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_data.w0        <= w0r;
      out_data.w1        <= wt[0];
      out_data.w2        <= wt[1];
      out_data.w3        <= wt[2];
      out_data.singular  <= sing;
      out_data.saturated <= sat;
    end
  end

endmodule

// ===== sv/tbw_checker.sv =====
`include "tetra_barycentric_weights_core_defines.svh"

module tbw_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input tbw_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input tbw_pkg::out_t out_data
);
  import tbw_pkg::*;

  `TBW_ASSERT_RST(a_rst_clears_out, clk, rst, !out_valid)
  `TBW_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `TBW_ASSERT_IMP(a_singular_zero, clk, rst, out_valid && out_data.singular, out_data.w0 == '0 && out_data.w1 == '0 && out_data.w2 == '0 && out_data.w3 == '0 && !out_data.saturated)
  `TBW_ASSERT_NXT(a_query_busy, clk, rst, in_valid && !in_stall && in_data.cmd == CMD_QUERY, in_stall)
  `TBW_ASSERT_NXT(a_load_free, clk, rst, in_valid && !in_stall && in_data.cmd == CMD_LOAD, !in_stall)

endmodule

bind tetra_barycentric_weights_core tbw_checker u_tbw_checker (.*);
